// ===== hw/rtl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Luhn card number classifier package
// Shared types, codes and small digit functions.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int unsigned BIN_W    = 64;
    localparam int unsigned NDIGITS  = 20;
    localparam int unsigned BCD_W    = 4 * NDIGITS;
    localparam int unsigned BITCNT_W = 6;
    localparam int unsigned OUT_W    = 24;

    localparam logic [1:0] TYPE_INVALID    = 2'd0;
    localparam logic [1:0] TYPE_AMEX       = 2'd1;
    localparam logic [1:0] TYPE_MASTERCARD = 2'd2;
    localparam logic [1:0] TYPE_VISA       = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_WALK,
        ST_HEAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic walk_step;
        logic head_calc;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic bcd_zero;
        logic out_busy;
    } sts_t;

    // Digit sum of twice a decimal digit.
    function automatic logic [3:0] dbl_digit(input logic [3:0] d);
        logic [4:0] p;
        begin
            p = {d, 1'b0};
            if (p >= 5'd10)
                dbl_digit = 4'(p - 5'd9);
            else
                dbl_digit = p[3:0];
        end
    endfunction

    // Remainder by ten of an 8-bit value through a reciprocal multiply.
    function automatic logic [3:0] mod10(input logic [7:0] x);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  qx10;
        begin
            prod  = 16'(x) * 16'd205;
            q     = prod[15:11];
            qx10  = 8'(q) * 8'd10;
            mod10 = 4'(x - qx10);
        end
    endfunction

endpackage

// ===== hw/rtl/lcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Luhn classifier controller
// Sequences conversion, digit walk, head calculation and result hand-off.
// ----------------------------------------------------------------------------
module lcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  lcc_pkg::sts_t sts,
    output lcc_pkg::cmd_t cmd
);
    import lcc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_CONVERT;
            end
            ST_CONVERT:
            begin
                if (sts.conv_last)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (sts.bcd_zero)
                    state_next = ST_HEAD;
            end
            ST_HEAD:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            ST_CONVERT:
                cmd.conv_step = 1'b1;
            ST_WALK:
                cmd.walk_step = !sts.bcd_zero;
            ST_HEAD:
                cmd.head_calc = 1'b1;
            ST_EMIT:
                cmd.emit = !sts.out_busy;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/lcc_datapath.sv =====
// ----------------------------------------------------------------------------
// Luhn classifier datapath
// Shift-and-add-3 decimal conversion, digit walk and output register.
// ----------------------------------------------------------------------------
module lcc_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [63:0]               s_axis_tdata,
    input  lcc_pkg::cmd_t             cmd,
    output lcc_pkg::sts_t             sts,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [lcc_pkg::OUT_W-1:0] m_axis_tdata
);
    import lcc_pkg::*;

    logic [BIN_W-1:0]    bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_adj;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [7:0]          sum_reg;
    logic [4:0]          count_reg;
    logic [3:0]          hi_reg;
    logic [3:0]          lo_reg;
    logic [6:0]          head_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;
    logic [3:0]          cur_digit;
    logic [3:0]          add_digit;
    logic [6:0]          head_next;
    logic                ok;
    logic [1:0]          kind;

    always_comb
    begin
        for (int i = 0; i < NDIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign cur_digit = bcd_reg[3:0];
    assign add_digit = count_reg[0] ? dbl_digit(cur_digit) : cur_digit;
    assign head_next = (count_reg >= 5'd2) ? (7'(hi_reg) * 7'd10 + 7'(lo_reg)) : 7'(hi_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg     <= s_axis_tdata;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            hi_reg      <= '0;
            lo_reg      <= '0;
        end
        else if (cmd.conv_step)
        begin
            bcd_reg     <= {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_reg     <= {bin_reg[BIN_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + BITCNT_W'(1);
        end
        else if (cmd.walk_step)
        begin
            bcd_reg   <= {4'd0, bcd_reg[BCD_W-1:4]};
            sum_reg   <= sum_reg + 8'(add_digit);
            count_reg <= count_reg + 5'd1;
            lo_reg    <= hi_reg;
            hi_reg    <= cur_digit;
        end
        if (cmd.head_calc)
            head_reg <= head_next;
    end

    always_comb
    begin
        ok   = (mod10(sum_reg) == 4'd0);
        kind = TYPE_INVALID;
        if (ok && count_reg != 5'd0)
        begin
            if (count_reg == 5'd15 && (head_reg == 7'd34 || head_reg == 7'd37))
                kind = TYPE_AMEX;
            else if (count_reg == 5'd16 && head_reg >= 7'd51 && head_reg <= 7'd55)
                kind = TYPE_MASTERCARD;
            else if ((count_reg == 5'd13 || count_reg == 5'd16)
                     && head_reg >= 7'd40 && head_reg <= 7'd49)
                kind = TYPE_VISA;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_data_reg <= {1'b0, head_reg, count_reg, sum_reg, ok, kind};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign sts.conv_last = (bit_cnt_reg == BITCNT_W'(BIN_W - 1));
    assign sts.bcd_zero  = (bcd_reg == '0);
    assign sts.out_busy  = out_valid_reg && !m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_axis_tready))
        else $error("result written over an untaken result");
    a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (bcd_reg != '0))
        else $error("digit walk past the last digit");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head_calc |-> (count_reg <= 5'd20))
        else $error("digit count out of range");
    a_conv_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv_step |-> !(cmd.walk_step || cmd.load || cmd.emit))
        else $error("conversion overlaps another command");
`endif

endmodule

// ===== hw/rtl/luhn_card_number_classifier.sv =====
// Flow: an accepted item runs through the binary-to-decimal shift loop, the
// one-digit-per-cycle Luhn walk over its n decimal digits (0 to 20), the head
// calculation and the result register. A new item is accepted only in idle,
// once the previous result has been written to the output register.
// Reset: rst_n clears the controller to idle and drops the output valid.
// ----------------------------------------------------------------------------
// Luhn card number classifier
// Checks the Luhn sum of a binary card number and classifies the issuer.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // card_number[63:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // card_type[1:0], luhn_ok[2], luhn_sum[10:3],
                                        // digit_count[15:11], leading_two[22:16], zero[23]
);
    import lcc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lcc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    lcc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
